>>> rtl/core/stop_and_wait_upload_sender_unit_defines.svh
// Assertion macros for the stop-and-wait upload sender.
// Used by the top level; no other dependencies.
`ifndef STOP_AND_WAIT_UPLOAD_SENDER_UNIT_DEFINES_SVH
`define STOP_AND_WAIT_UPLOAD_SENDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SWUS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SWUS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`define SWUS_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("assertion failed");
`else
`define SWUS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SWUS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define SWUS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

>>> rtl/core/swus_pkg.sv
// Shared types and constants for the stop-and-wait upload sender.
// No dependencies.
package swus_pkg;

	localparam logic [10:0] BLOCK_BYTES = 11'd1024;
	localparam logic [7:0]  CRED_MAX    = 8'd64;
	localparam logic [8:0]  NAME_BUF    = 9'd16;
	localparam logic [7:0]  NAME_MIN    = 8'd4;
	localparam logic [7:0]  NAME_MAX    = 8'd10;
	localparam logic [7:0]  T_HELLO     = 8'd1;
	localparam logic [7:0]  T_WRQ       = 8'd2;

	localparam int          CFG_IDX_W   = 2;
	localparam logic [3:0]  RETRY_RST   = 4'd5;
	localparam logic [7:0]  ACK_RST     = 8'd4;
	localparam logic [7:0]  DATA_RST    = 8'd3;
	localparam logic [7:0]  FIN_RST     = 8'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RETRY_LIMIT = 2'd0,
		REG_ACK_CODE    = 2'd1,
		REG_DATA_CODE   = 2'd2,
		REG_FIN_CODE    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CMD_START   = 3'd0,
		CMD_BLOCK   = 3'd1,
		CMD_EOS     = 3'd2,
		CMD_REPLY   = 3'd3,
		CMD_TIMEOUT = 3'd4,
		CMD_IOERR   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HELLO = 3'd1,
		PH_WRQ   = 3'd2,
		PH_DATA  = 3'd3,
		PH_FIN   = 3'd4,
		PH_DONE  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY      = 3'd0,
		ST_DONE      = 3'd1,
		ST_BAD_CRED  = 3'd2,
		ST_BAD_NAME  = 3'd3,
		ST_REJECTED  = 3'd4,
		ST_RETRIES   = 3'd5,
		ST_IO_ERROR  = 3'd6
	} status_t;

	typedef struct packed {
		logic [3:0] retry_limit;
		logic [7:0] ack_code;
		logic [7:0] data_code;
		logic [7:0] fin_code;
	} cfg_t;

	// first member sits in the top bits
	typedef struct packed {
		logic [7:0]  reply_seq;
		logic [7:0]  reply_type;
		logic [10:0] reply_length;
		logic [10:0] block_length;
		logic        name_is_ascii;
		logic [7:0]  name_length;
		logic [7:0]  cred_length;
	} item_t;

	typedef struct packed {
		logic [2:0]  phase_now;
		logic [2:0]  status;
		logic        want_block;
		logic [10:0] send_payload_length;
		logic        send_seq;
		logic [7:0]  send_type;
		logic        send_now;
	} result_t;

endpackage

>>> rtl/core/swus_cfg.sv
// Configuration register bank for the upload sender.
// Depends on swus_pkg.
module swus_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [swus_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data,
	output swus_pkg::cfg_t                cfg
);

	swus_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_limit <= swus_pkg::RETRY_RST;
			cfg_q.ack_code    <= swus_pkg::ACK_RST;
			cfg_q.data_code   <= swus_pkg::DATA_RST;
			cfg_q.fin_code    <= swus_pkg::FIN_RST;
		end else if (wr_en) begin
			unique case (swus_pkg::cfg_reg_t'(wr_index))
				swus_pkg::REG_RETRY_LIMIT: cfg_q.retry_limit <= wr_data[3:0];
				swus_pkg::REG_ACK_CODE:    cfg_q.ack_code    <= wr_data;
				swus_pkg::REG_DATA_CODE:   cfg_q.data_code   <= wr_data;
				swus_pkg::REG_FIN_CODE:    cfg_q.fin_code    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/swus_core.sv
// Protocol state and next-state logic of the upload sender.
// Depends on swus_pkg; one item is evaluated per enabled cycle.
module swus_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [2:0]        cmd,
	input  swus_pkg::item_t   item,
	input  swus_pkg::cfg_t    cfg,
	output swus_pkg::result_t res
);

	swus_pkg::phase_t phase_q, phase_d;
	logic        seq_q, seq_d;
	logic [3:0]  attempts_q, attempts_d;
	logic [7:0]  pend_type_q, pend_type_d;
	logic [10:0] pend_len_q, pend_len_d;
	logic        await_q, await_d;
	logic [3:0]  saved_nlen_q, saved_nlen_d;

	logic        busy;
	logic        name_ok;
	logic        cred_bad;
	logic        lost;
	logic [10:0] name_pdu_len;
	logic [10:0] blk_len;
	logic        send;
	logic [7:0]  send_type;
	logic [10:0] send_len;
	swus_pkg::status_t status;

	assign busy = (phase_q == swus_pkg::PH_HELLO) || (phase_q == swus_pkg::PH_WRQ) ||
		(phase_q == swus_pkg::PH_DATA) || (phase_q == swus_pkg::PH_FIN);
	assign name_ok = (item.name_length >= swus_pkg::NAME_MIN) &&
		(item.name_length <= swus_pkg::NAME_MAX) && item.name_is_ascii &&
		(({1'b0, item.name_length} + 9'd1) <= swus_pkg::NAME_BUF);
	assign cred_bad = (item.cred_length == 8'd0) || (item.cred_length >= swus_pkg::CRED_MAX);
	assign lost = (swus_pkg::cmd_t'(cmd) == swus_pkg::CMD_TIMEOUT) ||
		(item.reply_length < 11'd2) || (item.reply_type != cfg.ack_code) ||
		(item.reply_seq != {7'd0, seq_q});
	assign name_pdu_len = {7'd0, saved_nlen_q} + 11'd1;
	assign blk_len = (item.block_length > swus_pkg::BLOCK_BYTES) ?
		swus_pkg::BLOCK_BYTES : item.block_length;

	always_comb begin
		phase_d      = phase_q;
		seq_d        = seq_q;
		attempts_d   = attempts_q;
		pend_type_d  = pend_type_q;
		pend_len_d   = pend_len_q;
		await_d      = await_q;
		saved_nlen_d = saved_nlen_q;
		send         = 1'b0;
		send_type    = 8'd0;
		send_len     = 11'd0;
		status       = swus_pkg::ST_BUSY;

		unique case (swus_pkg::cmd_t'(cmd))
			swus_pkg::CMD_START: begin
				if (!busy) begin
					saved_nlen_d = name_ok ? item.name_length[3:0] : 4'd0;
					if (cred_bad) begin
						phase_d = swus_pkg::PH_IDLE;
						await_d = 1'b0;
						status  = swus_pkg::ST_BAD_CRED;
					end else begin
						phase_d     = swus_pkg::PH_HELLO;
						seq_d       = 1'b0;
						pend_type_d = swus_pkg::T_HELLO;
						pend_len_d  = {3'd0, item.cred_length};
						attempts_d  = 4'd1;
						await_d     = 1'b1;
						send        = 1'b1;
					end
				end
			end
			swus_pkg::CMD_BLOCK, swus_pkg::CMD_EOS: begin
				if (phase_q == swus_pkg::PH_DATA && !await_q) begin
					attempts_d = 4'd1;
					await_d    = 1'b1;
					send       = 1'b1;
					// an empty block closes the transfer like end of source
					if (swus_pkg::cmd_t'(cmd) == swus_pkg::CMD_EOS ||
						item.block_length == 11'd0) begin
						phase_d     = swus_pkg::PH_FIN;
						pend_type_d = cfg.fin_code;
						pend_len_d  = name_pdu_len;
					end else begin
						pend_type_d = cfg.data_code;
						pend_len_d  = blk_len;
					end
				end
			end
			swus_pkg::CMD_REPLY, swus_pkg::CMD_TIMEOUT: begin
				if (busy && await_q) begin
					priority if (lost) begin
						if (attempts_q >= cfg.retry_limit) begin
							phase_d = swus_pkg::PH_IDLE;
							await_d = 1'b0;
							status  = swus_pkg::ST_RETRIES;
						end else begin
							attempts_d = attempts_q + 4'd1;
							send       = 1'b1;
						end
					end else if (item.reply_length > 11'd2) begin
						phase_d = swus_pkg::PH_IDLE;
						await_d = 1'b0;
						status  = swus_pkg::ST_REJECTED;
					end else begin
						await_d = 1'b0;
						unique case (phase_q)
							swus_pkg::PH_HELLO: begin
								if (saved_nlen_q == 4'd0) begin
									phase_d = swus_pkg::PH_IDLE;
									status  = swus_pkg::ST_BAD_NAME;
								end else begin
									phase_d     = swus_pkg::PH_WRQ;
									seq_d       = 1'b1;
									pend_type_d = swus_pkg::T_WRQ;
									pend_len_d  = name_pdu_len;
									attempts_d  = 4'd1;
									await_d     = 1'b1;
									send        = 1'b1;
								end
							end
							swus_pkg::PH_WRQ: begin
								phase_d = swus_pkg::PH_DATA;
								seq_d   = 1'b0;
							end
							swus_pkg::PH_DATA: seq_d = ~seq_q;
							default: begin
								phase_d = swus_pkg::PH_DONE;
								status  = swus_pkg::ST_DONE;
							end
						endcase
					end
				end
			end
			swus_pkg::CMD_IOERR: begin
				if (busy) begin
					phase_d = swus_pkg::PH_IDLE;
					await_d = 1'b0;
					status  = swus_pkg::ST_IO_ERROR;
				end
			end
			default: ;
		endcase

		if (send) begin
			send_type = pend_type_d;
			send_len  = pend_len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= swus_pkg::PH_IDLE;
			seq_q        <= 1'b0;
			attempts_q   <= 4'd0;
			pend_type_q  <= 8'd0;
			pend_len_q   <= 11'd0;
			await_q      <= 1'b0;
			saved_nlen_q <= 4'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			seq_q        <= seq_d;
			attempts_q   <= attempts_d;
			pend_type_q  <= pend_type_d;
			pend_len_q   <= pend_len_d;
			await_q      <= await_d;
			saved_nlen_q <= saved_nlen_d;
		end
	end

	assign res.send_now            = send;
	assign res.send_type           = send_type;
	assign res.send_seq            = send & seq_d;
	assign res.send_payload_length = send_len;
	assign res.want_block          = (phase_d == swus_pkg::PH_DATA) && !await_d;
	assign res.status              = status;
	assign res.phase_now           = phase_d;

endmodule

>>> rtl/core/stop_and_wait_upload_sender_unit.sv
// Stop-and-wait upload sender: top level with input and result registers.
// Depends on swus_pkg, swus_cfg, swus_core and the defines header.
//
// Usage:
//  - s_* takes event items: s_tuser carries the event code, s_tdata the
//    lengths and the reply header fields.
//  - m_* gives one result item per event: whether a PDU goes out now and
//    its header, whether a new data block is wanted, the end status and
//    the phase after the event.
//  - cfg_* writes the retry limit and the PDU type codes; write only while
//    no event is in flight. cfg_ready is always high.
//  - An accepted item sits in the input register, and the protocol step
//    fills the result register once it is free or is being taken.
//  - Throughput is one item per cycle while m_tready stays high; the state
//    update is a single compare-and-select step between the input and result registers.
//  - Reset puts the configuration and state registers at their default values
//    and the protocol in idle; no PDU is pending.
//  - When m_tready is low the result register holds, the input register
//    fills behind it, and s_tready drops only once both are occupied.
`include "stop_and_wait_upload_sender_unit_defines.svh"

module stop_and_wait_upload_sender_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cred_length[7:0], name_length[15:8], name_is_ascii[16],
	// block_length[27:17], reply_length[38:28], reply_type[46:39],
	// reply_seq[54:47], zero[55]
	input  logic [55:0]                   s_tdata,
	// cmd[2:0]
	input  logic [2:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// send_now[0], send_type[8:1], send_seq[9], send_payload_length[20:10],
	// want_block[21], status[24:22], phase_now[27:25], zero[31:28]
	output logic [31:0]                   m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [swus_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	logic              valid_s1;
	swus_pkg::item_t   item_s1;
	logic [2:0]        cmd_s1;
	logic              advance;
	logic              out_valid_q;
	swus_pkg::result_t res_q;
	swus_pkg::result_t res_d;
	swus_pkg::cfg_t    cfg;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	swus_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	swus_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cmd    (cmd_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_tdata[54:0];
			cmd_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, res_q};

	// a stalled item in the input register is never dropped
	`SWUS_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1)
	// every step lands in the result register
	`SWUS_ASSERT_NEXT(a_res_load, clk, arst_n, advance, m_tvalid)
	// a block request means nothing awaits an ACK, so no PDU goes out with it
	`SWUS_ASSERT_NEVER(a_want_send, clk, arst_n, m_tvalid && res_q.want_block && res_q.send_now)
	// an end status leaves the protocol idle or finished
	`SWUS_ASSERT_IMPL(a_end_phase, clk, arst_n,
		m_tvalid && (res_q.status != swus_pkg::ST_BUSY),
		(res_q.phase_now == swus_pkg::PH_IDLE) || (res_q.phase_now == swus_pkg::PH_DONE))

endmodule
